@@ hw/rtl/differential_methylation_site_test_unit_assert.svh @@
// Assertion macros used by the checker file.
`ifndef DIFFERENTIAL_METHYLATION_SITE_TEST_UNIT_ASSERT_SVH
`define DIFFERENTIAL_METHYLATION_SITE_TEST_UNIT_ASSERT_SVH

// Checked only outside reset.
`define DMST_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dmst assertion failed");

// Checked during reset too.
`define DMST_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dmst assertion failed");

`endif

@@ hw/rtl/dmst_pkg.sv @@
// Package: constants, codes and types of the methylation site test unit.
`default_nettype none

package dmst_pkg;

  localparam int MAX_READS_DEF = 1024;
  localparam int LEVEL_BINS    = 256;
  localparam int BIN_AW        = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_HAP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TOTAL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPREAD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Z_CRIT_SQ  = 3'd4;

  localparam logic [10:0] MIN_HAP_RST    = 11'd2;
  localparam logic [11:0] MIN_TOTAL_RST  = 12'd6;
  localparam logic [9:0]  MIN_GAP_RST    = 10'd250;
  localparam logic [9:0]  MAX_SPREAD_RST = 10'd200;
  localparam logic [23:0] Z_CRIT_SQ_RST  = 24'd251754;

  localparam logic [1:0] HAP_ONE = 2'd1;
  localparam logic [1:0] HAP_TWO = 2'd2;

  localparam logic [2:0] VERDICT_INFORMATIVE = 3'd0;
  localparam logic [2:0] VERDICT_LOW_HAP     = 3'd1;
  localparam logic [2:0] VERDICT_LOW_TOTAL   = 3'd2;
  localparam logic [2:0] VERDICT_SMALL_GAP   = 3'd3;
  localparam logic [2:0] VERDICT_HIGH_SPREAD = 3'd4;
  localparam logic [2:0] VERDICT_NOT_SIGNIF  = 3'd5;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAIN,
    ST_WALK,
    ST_GAP_MUL,
    ST_GAP_SCALE,
    ST_GAP_RHS,
    ST_GAP_CMP,
    ST_SPR_MUL,
    ST_SPR_SCALE,
    ST_SPR_RHS,
    ST_SPR_CMP,
    ST_TST_SQ,
    ST_TST_DEV,
    ST_TST_MUL,
    ST_TST_SCALE,
    ST_TST_CMP
  } dmst_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/dmst_ram.sv @@
// Generic single-write, single-read RAM with registered read (read-first).
`default_nettype none

module dmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/differential_methylation_site_test_unit.sv @@
// Top level: per-site haplotype methylation test (rank-sum test, normal approx).
//
// Usage notes
//  - Input stream s_axis_*: one word per read. tdata = methyl_level, tuser =
//    haplotype, tlast = last_read. A read is used when its level is non-zero,
//    its haplotype is 1 or 2 and that haplotype holds fewer than MAX_READS.
//  - Output stream m_axis_*: one word per site, on the read marked last.
//  - Config channel cfg_*: register index and data, always ready; write only
//    while the block is idle. Unknown indexes are dropped.
//  - Reads are taken one per cycle while idle; a bin update is a read-modify-write
//    of a histogram RAM, with the previous write forwarded on a same-bin hit.
//  - On the last read the block stops taking words for a drain step, a walk
//    over both histograms (rank sum, bins cleared as it goes) and the shared
//    multiply/compare steps for gap, spread and test: m_axis_tvalid rises once
//    the final step has loaded the verdict word.
//  - The verdict sits in an output register; the next site streams in while
//    it waits. Only a later verdict stalls, in its final step, until taken.
//  - Reset (rst, synchronous): registers to defaults, then a clearing pass
//    zeroes the histogram RAMs; s_axis_tready stays low.
`default_nettype none

module differential_methylation_site_test_unit #(
  parameter int MAX_READS = dmst_pkg::MAX_READS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // input words
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,  // [7:0] methyl_level
  input  wire logic [1:0]                      s_axis_tuser,  // [1:0] haplotype
  input  wire logic                            s_axis_tlast,  // last_read
  // verdict words
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [7:0]                           m_axis_tdata,  // [0] informative, [3:1] verdict
  // configuration writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [dmst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dmst_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_READS + 1);  // per-haplotype count / bin
  localparam int NW = CW + 1;                 // total count
  localparam int SW = CW + 8;                 // level sum
  localparam int QW = CW + 16;                // level square sum
  localparam int PW = 2 * CW;                 // n1*n2
  localparam int MW = CW + 3;                 // 2*cum + t + 1
  localparam int RW = 2 * CW + 4;             // twice rank sum
  localparam int WW = 4 * CW + 26;            // datapath words
  localparam int BW = dmst_pkg::BIN_AW;
  localparam int XW = (NW > 12) ? NW : 12;    // count vs threshold compares

  // configuration
  logic [10:0] min_hap;
  logic [11:0] min_total;
  logic [9:0]  min_gap;
  logic [9:0]  max_spread;
  logic [23:0] z_crit_sq;

  // site summaries
  logic [CW-1:0] n1, n2;
  logic [SW-1:0] s1, s2;
  logic [QW-1:0] q1, q2;

  dmst_pkg::dmst_state_t state, state_next;

  // histogram pipeline
  logic          s1_valid;
  logic [1:0]    s1_hap;
  logic [BW-1:0] s1_addr;
  logic          fwd_valid;
  logic [1:0]    fwd_hap;
  logic [BW-1:0] fwd_addr;
  logic [CW-1:0] fwd_data;
  logic [CW-1:0] bin_old, bin_new;

  logic          ram_we1, ram_we2;
  logic [BW-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0] ram_wdata;
  logic [CW-1:0] rd1, rd2;

  // walk
  logic [BW:0]   wc;
  logic          wv;
  logic          walk_issue;
  logic [CW:0]   cum;
  logic [RW-1:0] twice_r1;
  logic [CW:0]   bin_tot;
  logic [MW-1:0] rank_mul;

  // test datapath
  logic [WW-1:0] op_a, op_b, op_c;
  logic [PW-1:0] prodn;
  logic          hsel;
  logic          f_gap, f_spr;
  logic [WW-1:0] diff_ab, twice_u1;
  logic [CW-1:0] n_h;
  logic [SW-1:0] s_h;
  logic [QW-1:0] q_h;
  logic [NW-1:0] n_tot;
  logic [2:0]    verdict;
  logic          out_free;

  logic       in_acc;
  logic [7:0] lvl;
  logic       use1, use2;
  logic [15:0] lvl_sq;

  logic       ov;
  logic       o_inf;
  logic [2:0] o_ver;

  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = ov;
  assign m_axis_tdata  = {4'b0000, o_ver, o_inf};

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign lvl    = s_axis_tdata;
  assign lvl_sq = 16'(lvl) * 16'(lvl);
  assign use1   = in_acc && (lvl != 8'd0) && (s_axis_tuser == dmst_pkg::HAP_ONE)
                  && (n1 < CW'(MAX_READS));
  assign use2   = in_acc && (lvl != 8'd0) && (s_axis_tuser == dmst_pkg::HAP_TWO)
                  && (n2 < CW'(MAX_READS));

  assign out_free = !ov || m_axis_tready;
  assign n_tot    = NW'(n1) + NW'(n2);

  // one RAM per haplotype
  dmst_ram #(.WIDTH(CW), .DEPTH(dmst_pkg::LEVEL_BINS)) u_hist_one (
    .clk  (clk),
    .we   (ram_we1),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rd1)
  );

  dmst_ram #(.WIDTH(CW), .DEPTH(dmst_pkg::LEVEL_BINS)) u_hist_two (
    .clk  (clk),
    .we   (ram_we2),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rd2)
  );

  // bin read-modify-write; last write forwarded when it hits the same bin
  always_comb begin
    if (fwd_valid && (fwd_hap == s1_hap) && (fwd_addr == s1_addr)) begin
      bin_old = fwd_data;
    end else if (s1_hap == dmst_pkg::HAP_ONE) begin
      bin_old = rd1;
    end else begin
      bin_old = rd2;
    end
    bin_new = bin_old + CW'(1);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dmst_pkg::ST_CLEAR:     if (wc == (BW+1)'(dmst_pkg::LEVEL_BINS - 1)) begin
                                state_next = dmst_pkg::ST_IDLE;
                              end
      dmst_pkg::ST_IDLE:      if (in_acc && s_axis_tlast) begin
                                state_next = dmst_pkg::ST_DRAIN;
                              end
      dmst_pkg::ST_DRAIN:     state_next = dmst_pkg::ST_WALK;
      dmst_pkg::ST_WALK:      if (wc[BW]) begin
                                state_next = dmst_pkg::ST_GAP_MUL;
                              end
      dmst_pkg::ST_GAP_MUL:   state_next = dmst_pkg::ST_GAP_SCALE;
      dmst_pkg::ST_GAP_SCALE: state_next = dmst_pkg::ST_GAP_RHS;
      dmst_pkg::ST_GAP_RHS:   state_next = dmst_pkg::ST_GAP_CMP;
      dmst_pkg::ST_GAP_CMP:   state_next = dmst_pkg::ST_SPR_MUL;
      dmst_pkg::ST_SPR_MUL:   state_next = dmst_pkg::ST_SPR_SCALE;
      dmst_pkg::ST_SPR_SCALE: state_next = dmst_pkg::ST_SPR_RHS;
      dmst_pkg::ST_SPR_RHS:   state_next = dmst_pkg::ST_SPR_CMP;
      dmst_pkg::ST_SPR_CMP:   state_next = hsel ? dmst_pkg::ST_TST_SQ : dmst_pkg::ST_SPR_MUL;
      dmst_pkg::ST_TST_SQ:    state_next = dmst_pkg::ST_TST_DEV;
      dmst_pkg::ST_TST_DEV:   state_next = dmst_pkg::ST_TST_MUL;
      dmst_pkg::ST_TST_MUL:   state_next = dmst_pkg::ST_TST_SCALE;
      dmst_pkg::ST_TST_SCALE: state_next = dmst_pkg::ST_TST_CMP;
      dmst_pkg::ST_TST_CMP:   if (out_free) begin
                                state_next = dmst_pkg::ST_IDLE;
                              end
      default:                state_next = dmst_pkg::ST_CLEAR;
    endcase
  end

  // RAM control and input ready
  always_comb begin
    s_axis_tready = 1'b0;
    walk_issue    = 1'b0;
    ram_raddr     = lvl;
    ram_waddr     = s1_addr;
    ram_wdata     = bin_new;
    ram_we1       = s1_valid && (s1_hap == dmst_pkg::HAP_ONE);
    ram_we2       = s1_valid && (s1_hap == dmst_pkg::HAP_TWO);
    unique case (state)
      dmst_pkg::ST_CLEAR, dmst_pkg::ST_WALK: begin
        walk_issue = !wc[BW];
        ram_raddr  = wc[BW-1:0];
        ram_waddr  = wc[BW-1:0];
        ram_wdata  = '0;
        ram_we1    = walk_issue;
        ram_we2    = walk_issue;
      end
      dmst_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // operand select for the spread test
  assign n_h = hsel ? n2 : n1;
  assign s_h = hsel ? s2 : s1;
  assign q_h = hsel ? q2 : q1;

  assign diff_ab  = (op_a >= op_b) ? (op_a - op_b) : (op_b - op_a);
  assign twice_u1 = WW'(twice_r1) - op_c;
  assign bin_tot  = (CW+1)'(rd1) + (CW+1)'(rd2);
  assign rank_mul = MW'({cum, 1'b0}) + MW'(bin_tot) + MW'(1);

  // verdict priority
  always_comb begin
    if ((XW'(n1) < XW'(min_hap)) || (XW'(n2) < XW'(min_hap))) begin
      verdict = dmst_pkg::VERDICT_LOW_HAP;
    end else if (XW'(n_tot) < XW'(min_total)) begin
      verdict = dmst_pkg::VERDICT_LOW_TOTAL;
    end else if ((n1 == '0) || (n2 == '0)) begin
      verdict = dmst_pkg::VERDICT_NOT_SIGNIF;
    end else if (f_gap) begin
      verdict = dmst_pkg::VERDICT_SMALL_GAP;
    end else if (f_spr) begin
      verdict = dmst_pkg::VERDICT_HIGH_SPREAD;
    end else if (op_a > op_b) begin
      verdict = dmst_pkg::VERDICT_INFORMATIVE;
    end else begin
      verdict = dmst_pkg::VERDICT_NOT_SIGNIF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dmst_pkg::ST_CLEAR;
      min_hap    <= dmst_pkg::MIN_HAP_RST;
      min_total  <= dmst_pkg::MIN_TOTAL_RST;
      min_gap    <= dmst_pkg::MIN_GAP_RST;
      max_spread <= dmst_pkg::MAX_SPREAD_RST;
      z_crit_sq  <= dmst_pkg::Z_CRIT_SQ_RST;
      n1         <= '0;
      n2         <= '0;
      s1         <= '0;
      s2         <= '0;
      q1         <= '0;
      q2         <= '0;
      s1_valid   <= 1'b0;
      fwd_valid  <= 1'b0;
      wc         <= '0;
      wv         <= 1'b0;
      ov         <= 1'b0;
      hsel       <= 1'b0;
      f_gap      <= 1'b0;
      f_spr      <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          dmst_pkg::REG_MIN_HAP:    min_hap    <= cfg_data[10:0];
          dmst_pkg::REG_MIN_TOTAL:  min_total  <= cfg_data[11:0];
          dmst_pkg::REG_MIN_GAP:    min_gap    <= cfg_data[9:0];
          dmst_pkg::REG_MAX_SPREAD: max_spread <= cfg_data[9:0];
          dmst_pkg::REG_Z_CRIT_SQ:  z_crit_sq  <= cfg_data[23:0];
          default: begin
          end
        endcase
      end

      // verdict word: loaded in the final step, dropped once taken
      if ((state == dmst_pkg::ST_TST_CMP) && out_free) begin
        ov <= 1'b1;
      end else if (m_axis_tready) begin
        ov <= 1'b0;
      end

      // stream: summaries at accept, bin update in the next cycle
      if (use1) begin
        n1 <= n1 + CW'(1);
        s1 <= s1 + SW'(lvl);
        q1 <= q1 + QW'(lvl_sq);
      end
      if (use2) begin
        n2 <= n2 + CW'(1);
        s2 <= s2 + SW'(lvl);
        q2 <= q2 + QW'(lvl_sq);
      end
      s1_valid  <= use1 || use2;
      s1_hap    <= s_axis_tuser;
      s1_addr   <= lvl;
      fwd_valid <= s1_valid;
      fwd_hap   <= s1_hap;
      fwd_addr  <= s1_addr;
      fwd_data  <= bin_new;

      unique case (state)
        dmst_pkg::ST_CLEAR: begin
          wc <= wc + (BW+1)'(1);
        end
        dmst_pkg::ST_IDLE: begin
          wc <= '0;
        end
        dmst_pkg::ST_DRAIN: begin
          wc       <= '0;
          wv       <= 1'b0;
          cum      <= '0;
          twice_r1 <= '0;
          hsel     <= 1'b0;
          f_gap    <= 1'b0;
          f_spr    <= 1'b0;
        end
        dmst_pkg::ST_WALK: begin
          if (!wc[BW]) begin
            wc <= wc + (BW+1)'(1);
          end
          wv <= walk_issue;
          if (wv) begin
            twice_r1 <= twice_r1 + RW'(rd1) * RW'(rank_mul);
            cum      <= cum + bin_tot;
          end
        end
        dmst_pkg::ST_GAP_MUL: begin
          op_a <= WW'(s1) * WW'(n2);
          op_b <= WW'(s2) * WW'(n1);
        end
        dmst_pkg::ST_GAP_SCALE: begin
          op_a  <= diff_ab * WW'(1000);
          op_b  <= WW'(min_gap) * WW'(255);
          prodn <= PW'(n1) * PW'(n2);
        end
        dmst_pkg::ST_GAP_RHS: begin
          op_b <= WW'(prodn) * op_b[17:0];
        end
        dmst_pkg::ST_GAP_CMP: begin
          f_gap <= op_a < op_b;
        end
        dmst_pkg::ST_SPR_MUL: begin
          op_a <= WW'(n_h) * WW'(q_h);
          op_b <= WW'(s_h) * WW'(s_h);
          op_c <= WW'(max_spread) * WW'(51);
        end
        dmst_pkg::ST_SPR_SCALE: begin
          op_a <= (op_a - op_b) * WW'(40000);
          op_b <= WW'(op_c[15:0]) * WW'(op_c[15:0]);
          op_c <= WW'(n_h) * WW'(n_h);
        end
        dmst_pkg::ST_SPR_RHS: begin
          op_b <= WW'(op_b[31:0]) * WW'(op_c[PW-1:0]);
        end
        dmst_pkg::ST_SPR_CMP: begin
          if (op_a > op_b) begin
            f_spr <= 1'b1;
          end
          hsel <= 1'b1;
        end
        dmst_pkg::ST_TST_SQ: begin
          op_c <= WW'(n1) * (WW'(n1) + WW'(1));
          op_b <= WW'(prodn);
        end
        dmst_pkg::ST_TST_DEV: begin
          op_a <= (twice_u1 >= op_b) ? (twice_u1 - op_b) : (op_b - twice_u1);
        end
        dmst_pkg::ST_TST_MUL: begin
          op_a <= WW'(op_a[PW-1:0]) * WW'(op_a[PW-1:0]);
          op_b <= WW'(z_crit_sq) * WW'(prodn);
        end
        dmst_pkg::ST_TST_SCALE: begin
          op_a <= (op_a + (op_a << 1)) << 16;
          op_b <= WW'(op_b[PW+23:0]) * WW'(n_tot + NW'(1));
        end
        dmst_pkg::ST_TST_CMP: begin
          if (out_free) begin
            o_inf <= (verdict == dmst_pkg::VERDICT_INFORMATIVE);
            o_ver <= verdict;
            n1    <= '0;
            n2    <= '0;
            s1    <= '0;
            s2    <= '0;
            q1    <= '0;
            q2    <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/dmst_checker.sv @@
// Port-level checker for the methylation site test unit, bound to the top level.
`default_nettype none
`include "differential_methylation_site_test_unit_assert.svh"

module dmst_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata
);

  logic       inf_bit;
  logic [2:0] ver_code;
  logic       is_inf;
  logic       ver_ok;

  assign inf_bit  = m_axis_tdata[0];
  assign ver_code = m_axis_tdata[3:1];
  assign is_inf   = (ver_code == dmst_pkg::VERDICT_INFORMATIVE);
  assign ver_ok   = (ver_code <= dmst_pkg::VERDICT_NOT_SIGNIF) && (m_axis_tdata[7:4] == '0);

  // a verdict word waits until taken
  `DMST_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  // informative flag agrees with the verdict code
  `DMST_ASSERT(a_inf_match, clk, rst, m_axis_tvalid |-> (inf_bit == is_inf))
  // only defined verdicts, padding zero
  `DMST_ASSERT(a_ver_range, clk, rst, m_axis_tvalid |-> ver_ok)
  // clearing pass follows reset: no words taken, no verdict shown
  `DMST_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> (!s_axis_tready && !m_axis_tvalid))

endmodule

bind differential_methylation_site_test_unit dmst_checker u_dmst_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

@@ tb/tb.sv @@
// Testbench for the haplotype methylation site test unit: predicted verdicts
// checked against the verdict stream.
`timescale 1ns / 1ps

module tb;

  typedef logic [dmst_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [dmst_pkg::CFG_DATA_W-1:0] cfg_word_t;

  localparam logic [1:0] HAP_NONE  = 2'd0;
  localparam logic [1:0] HAP_SPARE = 2'd3;
  localparam cfg_idx_t REG_UNUSED = 3'd5;
  localparam int CAP = 1024;  // reads held per haplotype
  localparam int SETTLE = 300;  // drain + walk + tail, cycles
  localparam int HOLD_CYCLES = 1500;

  // Predicted verdicts for the block, one per site
  class site_verdict_board;
    int unsigned min_hap, min_total, gap_milli, spread_milli, zsq;
    longint unsigned hist1[dmst_pkg::LEVEL_BINS], hist2[dmst_pkg::LEVEL_BINS];
    longint unsigned n1, n2, s1, s2, q1, q2;
    logic [7:0] pending_verdicts[$];
    int errors, sites;
    int verdict_tally[6];

    function new();
      min_hap = dmst_pkg::MIN_HAP_RST; min_total = dmst_pkg::MIN_TOTAL_RST;
      gap_milli = dmst_pkg::MIN_GAP_RST; spread_milli = dmst_pkg::MAX_SPREAD_RST;
      zsq = dmst_pkg::Z_CRIT_SQ_RST;
      clear_site();
    endfunction

    function void clear_site();
      foreach (hist1[i]) begin
        hist1[i] = 0; hist2[i] = 0;
      end
      n1 = 0; n2 = 0; s1 = 0; s2 = 0; q1 = 0; q2 = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, cfg_word_t val);
      case (idx)
        dmst_pkg::REG_MIN_HAP:    min_hap = val[10:0];
        dmst_pkg::REG_MIN_TOTAL:  min_total = val[11:0];
        dmst_pkg::REG_MIN_GAP:    gap_milli = val[9:0];
        dmst_pkg::REG_MAX_SPREAD: spread_milli = val[9:0];
        dmst_pkg::REG_Z_CRIT_SQ:  zsq = val[23:0];
        default: ;
      endcase
    endfunction

    function bit spread_high(longint unsigned n, longint unsigned s, longint unsigned q);
      longint unsigned var_n2, lim;
      var_n2 = n * q - s * s;
      lim = 51 * spread_milli;
      return 40000 * var_n2 > lim * lim * n * n;
    endfunction

    function logic [2:0] predict_verdict();
      longint unsigned tot, x, y, diff, cum, twice_r1, twice_u1, prodn, dev, a, t;
      logic [127:0] lhs, rhs;
      tot = n1 + n2;
      if (n1 < min_hap || n2 < min_hap) return dmst_pkg::VERDICT_LOW_HAP;
      if (tot < min_total) return dmst_pkg::VERDICT_LOW_TOTAL;
      if (n1 == 0 || n2 == 0) return dmst_pkg::VERDICT_NOT_SIGNIF;
      x = s1 * n2; y = s2 * n1;
      diff = x >= y ? x - y : y - x;
      if (1000 * diff < longint'(gap_milli) * 255 * n1 * n2)
        return dmst_pkg::VERDICT_SMALL_GAP;
      if (spread_high(n1, s1, q1) || spread_high(n2, s2, q2))
        return dmst_pkg::VERDICT_HIGH_SPREAD;
      cum = 0; twice_r1 = 0;
      for (int b = 0; b < dmst_pkg::LEVEL_BINS; b++) begin
        a = hist1[b];
        t = a + hist2[b];
        twice_r1 += a * (2 * cum + t + 1);
        cum += t;
      end
      twice_u1 = twice_r1 - n1 * (n1 + 1);
      prodn = n1 * n2;
      dev = twice_u1 >= prodn ? twice_u1 - prodn : prodn - twice_u1;
      lhs = 128'(3 * dev) * 128'(dev << 16);
      rhs = 128'(longint'(zsq) * prodn) * 128'(tot + 1);
      return lhs > rhs ? dmst_pkg::VERDICT_INFORMATIVE : dmst_pkg::VERDICT_NOT_SIGNIF;
    endfunction

    // accepted read word
    function void note_read(logic [7:0] level, logic [1:0] hap, logic last);
      logic [2:0] v;
      logic [7:0] w;
      if (level != 0) begin
        if (hap == dmst_pkg::HAP_ONE && n1 < CAP) begin
          hist1[level]++; n1++; s1 += level; q1 += level * level;
        end else if (hap == dmst_pkg::HAP_TWO && n2 < CAP) begin
          hist2[level]++; n2++; s2 += level; q2 += level * level;
        end
      end
      if (last) begin
        v = predict_verdict();
        w = {4'b0, v, v == dmst_pkg::VERDICT_INFORMATIVE};
        pending_verdicts = {pending_verdicts, w};
        clear_site();
      end
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check(logic [7:0] got);
      logic [7:0] want;
      if (pending_verdicts.size() == 0) begin
        report($sformatf("verdict word %h with none outstanding", got));
        return;
      end
      want = pending_verdicts.pop_front();
      sites++;
      if (want[3:1] < 6) verdict_tally[want[3:1]]++;
      if (got[0] !== want[0])
        report($sformatf("site %0d informative %b, want %b", sites, got[0], want[0]));
      if (got[3:1] !== want[3:1])
        report($sformatf("site %0d verdict %0d, want %0d", sites, got[3:1], want[3:1]));
      if (got[7:4] !== 4'b0)
        report($sformatf("site %0d pad bits %h not zero", sites, got[7:4]));
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, s_axis_tlast = 0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 0;  // [7:0] methyl_level
  logic [1:0] s_axis_tuser = 0;  // [1:0] haplotype
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [7:0] m_axis_tdata;      // [0] informative, [3:1] verdict
  logic cfg_valid = 0, cfg_ready;
  cfg_idx_t cfg_index = 0;
  cfg_word_t cfg_data = 0;

  site_verdict_board board = new();
  bit calm = 0;  // no idling on either side while set
  int reads_sent = 0;

  always #5 clk = ~clk;

  differential_methylation_site_test_unit dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // Verdict side: random stalls, plus one long hold-off so the block backs
  // up and stalls its input while reads keep coming
  initial begin
    int hold_done;
    hold_done = 0;
    forever begin
      @(negedge clk);
      if (!hold_done && board.sites >= 20) begin
        hold_done = 1;
        m_axis_tready <= 0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_axis_tready <= calm || $urandom_range(99) >= 25;
    end
  end

  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready) board.check(m_axis_tdata);

  // one read word; tvalid is left high, the caller or next gap lowers it
  task send_read(logic [7:0] level, logic [1:0] hap, logic last);
    while (!calm && $urandom_range(99) < 25) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= level;
    s_axis_tuser <= hap;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    board.note_read(level, hap, last);
    reads_sent++;
    @(negedge clk);
  endtask

  task cfg_write(cfg_idx_t idx, cfg_word_t val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
    @(negedge clk);
  endtask

  // all five registers, then an unknown index, then the channel drops
  task configure(int unsigned hap_min, int unsigned tot_min, int unsigned gap,
                 int unsigned spread, int unsigned zsq);
    cfg_write(dmst_pkg::REG_MIN_HAP, cfg_word_t'(hap_min));
    cfg_write(dmst_pkg::REG_MIN_TOTAL, cfg_word_t'(tot_min));
    cfg_write(dmst_pkg::REG_MIN_GAP, cfg_word_t'(gap));
    cfg_write(dmst_pkg::REG_MAX_SPREAD, cfg_word_t'(spread));
    cfg_write(dmst_pkg::REG_Z_CRIT_SQ, cfg_word_t'(zsq));
    cfg_write(REG_UNUSED, cfg_word_t'($urandom));
    cfg_valid <= 0;
  endtask

  // wait for every verdict, then let the walk of a trailing site finish
  task settle();
    s_axis_tvalid <= 0;
    while (board.pending_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function logic [7:0] near(int centre, int spread);
    int v;
    v = centre + $urandom_range(2 * spread) - spread;
    return v < 1 ? 8'd1 : v > 255 ? 8'd255 : 8'(v);
  endfunction

  // one site: mostly two clusters of levels, some noise reads
  task random_site();
    int len, c1, c2, w;
    logic [1:0] hap;
    logic [7:0] level;
    len = $urandom_range(99) < 80 ? $urandom_range(4, 20) : $urandom_range(1, 40);
    c1 = $urandom_range(1, 255); c2 = $urandom_range(1, 255);
    w = $urandom_range(0, 60);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 10) begin
        hap = 2'($urandom);
        level = $urandom_range(99) < 50 ? 8'd0 : 8'($urandom);
      end else begin
        hap = $urandom_range(1) ? dmst_pkg::HAP_ONE : dmst_pkg::HAP_TWO;
        level = near(hap == dmst_pkg::HAP_ONE ? c1 : c2, w);
      end
      send_read(level, hap, i == len - 1);
    end
  endtask

  initial begin
    int sent;
    repeat (9) @(negedge clk);
    rst <= 0;
    repeat (SETTLE) @(negedge clk);  // histogram clearing pass

    // Directed, reset settings
    send_read(8'd0, HAP_NONE, 1);                   // nothing usable
    send_read(8'd90, HAP_SPARE, 0);                 // tag three ignored
    send_read(8'd0, dmst_pkg::HAP_ONE, 0);          // unset level ignored
    for (int i = 0; i < 4; i++) send_read(8'(250 + i), dmst_pkg::HAP_ONE, 0);
    for (int i = 0; i < 3; i++) send_read(8'(10 + i), dmst_pkg::HAP_TWO, 0);
    send_read(8'd13, dmst_pkg::HAP_TWO, 1);         // last read counted
    for (int i = 0; i < 3; i++) send_read(8'(100 + i), dmst_pkg::HAP_ONE, 0);
    for (int i = 0; i < 3; i++)
      send_read(8'(100 + i), dmst_pkg::HAP_TWO, i == 2);  // small gap
    for (int i = 0; i < 4; i++) send_read(i[0] ? 8'd255 : 8'd1, dmst_pkg::HAP_ONE, 0);
    for (int i = 0; i < 3; i++) send_read(8'd10, dmst_pkg::HAP_TWO, i == 2);  // wide spread
    send_read(8'd200, dmst_pkg::HAP_ONE, 0);
    send_read(8'd20, dmst_pkg::HAP_TWO, 1);         // too few reads per haplotype
    settle();

    // Zero thresholds but the spread limit: empty haplotype, then a full haplotype
    configure(0, 0, 0, 1000, 0);
    send_read(8'd255, dmst_pkg::HAP_ONE, 1);
    send_read(8'd0, dmst_pkg::HAP_TWO, 1);
    for (int i = 0; i < CAP + 6; i++) send_read(near(200, 40), dmst_pkg::HAP_ONE, 0);
    for (int i = 0; i < 5; i++) send_read(near(50, 10), dmst_pkg::HAP_TWO, i == 4);
    settle();

    // Top extremes, masked on the way in
    configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    for (int i = 0; i < 6; i++) random_site();
    settle();

    // Random phases; the second runs with no idling
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure(dmst_pkg::MIN_HAP_RST, dmst_pkg::MIN_TOTAL_RST,
                     dmst_pkg::MIN_GAP_RST, dmst_pkg::MAX_SPREAD_RST,
                     dmst_pkg::Z_CRIT_SQ_RST);
        5: configure(1, 2, 1000, 1000, 24'hFFFFFF);
        default: configure($urandom_range(0, 4), $urandom_range(0, 10),
                           $urandom_range(0, 400), $urandom_range(50, 700),
                           $urandom_range(99) < 30 ? $urandom_range(0, 24'hFFFFFF)
                                                   : $urandom_range(50000, 900000));
      endcase
      calm = (ph == 1);
      sent = reads_sent;
      while (reads_sent - sent < 70) random_site();
      settle();
      calm = 0;
    end

    $display("Checked %0d sites from %0d reads; verdicts 0..5: %0d %0d %0d %0d %0d %0d",
             board.sites, reads_sent, board.verdict_tally[0], board.verdict_tally[1],
             board.verdict_tally[2], board.verdict_tally[3], board.verdict_tally[4],
             board.verdict_tally[5]);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Timeout with %0d verdicts outstanding", board.pending_verdicts.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/dmst_pkg.sv
hw/rtl/dmst_ram.sv
hw/rtl/differential_methylation_site_test_unit.sv
hw/rtl/dmst_checker.sv
tb/tb.sv
